[hw/rtl/caa_pkg.sv]
// Package for the command authority arbiter: operation, source and stop
// reason codes, the queue entry type and fixed widths. No dependencies.
package caa_pkg;

  localparam int unsigned NumSrc    = 3;
  localparam int unsigned DemandW   = 11;
  localparam int unsigned MagW      = 17;  // |demand| * percent, at most 102400
  localparam int unsigned RecipW    = 18;
  localparam int unsigned RecipSh   = 24;
  // ceil(2^24 / 100): exact floor(x / 100) for x below about 199000
  localparam logic [RecipW-1:0] Recip100 = 18'd167773;
  localparam logic [6:0]  FullPct   = 7'd100;
  localparam logic [10:0] DemandMax = 11'd1000;

  typedef enum logic [1:0] {
    OP_DECIDE   = 2'd0,
    OP_HANDSET  = 2'd1,
    OP_TELEOP   = 2'd2,
    OP_AUTONOMY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_HANDSET  = 2'd1,
    SRC_TELEOP   = 2'd2,
    SRC_AUTONOMY = 2'd3
  } src_e;

  typedef enum logic [3:0] {
    RSN_NONE        = 4'd0,
    RSN_STARTUP     = 4'd1,
    RSN_HS_INVALID  = 4'd2,
    RSN_HS_STALE    = 4'd3,
    RSN_ESTOP       = 4'd4,
    RSN_TEL_INVALID = 4'd5,
    RSN_TEL_STALE   = 4'd6,
    RSN_ALLSTOP     = 4'd7,
    RSN_AUT_INVALID = 4'd8,
    RSN_AUT_STALE   = 4'd9
  } reason_e;

  typedef enum logic [1:0] {
    CFG_HS_TIMEOUT  = 2'd0,
    CFG_TEL_TIMEOUT = 2'd1,
    CFG_AUT_TIMEOUT = 2'd2,
    CFG_ALLOW_EARLY = 2'd3
  } cfg_e;

  // One classified request as it sits in the queue. Demands are already
  // multiplied by the clamped limit percent (100 for autonomy).
  typedef struct packed {
    op_e              op;
    logic [31:0]      now_ms;
    logic             cmd_valid;
    logic             cmd_request;
    logic             cmd_estop;
    logic             surge_neg;
    logic [MagW-1:0]  surge_mag;
    logic             yaw_neg;
    logic [MagW-1:0]  yaw_mag;
    logic [31:0]      cmd_seq;
    logic             halt_all;
  } entry_t;

endpackage

[hw/rtl/caa_front.sv]
// Front end: classifies an incoming request and forms its scaled demand
// product for the queue. Depends on caa_pkg.
module caa_front (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic [31:0]              now_ms_i,
  input  logic                     cmd_valid_i,
  input  logic                     cmd_request_i,
  input  logic                     cmd_estop_i,
  input  logic signed [10:0]       cmd_surge_i,
  input  logic signed [10:0]       cmd_yaw_i,
  input  logic [7:0]               cmd_limit_i,
  input  logic [31:0]              cmd_seq_i,
  input  logic                     halt_all_i,
  output logic                     push_o,
  output caa_pkg::entry_t          entry_o,
  input  logic                     q_full_i
);
  import caa_pkg::*;

  op_e                op;
  logic [6:0]         pct;
  logic               s_neg, y_neg;
  logic [DemandW-1:0] s_abs, y_abs;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    // autonomy passes unscaled: times 100, later divided by 100
    if (op == OP_AUTONOMY) begin
      pct = FullPct;
    end else if (cmd_limit_i > 8'(FullPct)) begin
      pct = FullPct;
    end else begin
      pct = cmd_limit_i[6:0];
    end
    s_neg = cmd_surge_i[10];
    y_neg = cmd_yaw_i[10];
    s_abs = s_neg ? DemandW'(-cmd_surge_i) : cmd_surge_i;
    y_abs = y_neg ? DemandW'(-cmd_yaw_i) : cmd_yaw_i;

    entry_o.op          = op;
    entry_o.now_ms      = now_ms_i;
    entry_o.cmd_valid   = cmd_valid_i;
    entry_o.cmd_request = (op == OP_AUTONOMY) ? 1'b0 : cmd_request_i;
    entry_o.cmd_estop   = (op == OP_TELEOP) ? cmd_estop_i : 1'b0;
    entry_o.surge_neg   = s_neg;
    entry_o.surge_mag   = MagW'(s_abs) * MagW'(pct);
    entry_o.yaw_neg     = y_neg;
    entry_o.yaw_mag     = MagW'(y_abs) * MagW'(pct);
    entry_o.cmd_seq     = cmd_seq_i;
    entry_o.halt_all    = halt_all_i;
  end

endmodule

[hw/rtl/caa_queue.sv]
// Two-entry request queue between front and back end.
// Depends on caa_pkg for the entry type.
module caa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  caa_pkg::entry_t  entry_i,
  output logic             full_o,
  output logic             head_valid_o,
  output caa_pkg::entry_t  head_o,
  input  logic             pop_i
);
  import caa_pkg::*;

  entry_t      mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/caa_back.sv]
// Back end: source mailboxes, timeout registers, the priority decision
// and the output register. Depends on caa_pkg.
module caa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                head_valid_i,
  input  caa_pkg::entry_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         decision_count_o,
  output logic [1:0]          grant_src_o,
  output logic                thrust_cut_o,
  output logic                manual_fault_o,
  output logic [3:0]          halt_cause_o,
  output logic signed [10:0]  surge_out_o,
  output logic signed [10:0]  yaw_out_o,
  output logic [31:0]         lineage_seq_o,
  output logic                owner_changed_o,
  output logic                reason_changed_o
);
  import caa_pkg::*;

  // configuration
  logic [15:0] timeout_q [NumSrc];
  logic        allow_early_q;

  // mailboxes; grant values are already scaled and saturated
  logic [NumSrc-1:0]       seen_q, valid_q, request_q, estop_q;
  logic signed [10:0]      gsurge_q [NumSrc];
  logic signed [10:0]      gyaw_q   [NumSrc];
  logic [31:0]             seq_q    [NumSrc];
  logic [31:0]             arr_q    [NumSrc];

  logic [31:0] count_q;
  src_e        last_src_q;
  reason_e     last_rsn_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] o_count_q;
  src_e        o_src_q;
  logic        o_stop_q, o_fc_q;
  reason_e     o_rsn_q;
  logic signed [10:0] o_surge_q, o_yaw_q;
  logic [31:0] o_lin_q;
  logic        o_ach_q, o_rch_q;

  logic        is_decide, is_arrival, take;
  logic [1:0]  wr_idx;
  logic [NumSrc-1:0] fresh;
  logic [32:0] diff [NumSrc];
  logic [31:0] age  [NumSrc];

  logic [MagW+RecipW-1:0] s_prod, y_prod;
  logic [DemandW-1:0]     s_q, y_q, s_c, y_c;
  logic signed [10:0]     new_surge, new_yaw;

  src_e               sel;
  reason_e            rsn;
  logic               stop, fclosed;
  logic signed [10:0] d_surge, d_yaw;
  logic [31:0]        lineage;

  assign is_decide  = (head_i.op == OP_DECIDE);
  assign is_arrival = head_valid_i && !is_decide;
  assign pop_o      = head_valid_i && (!is_decide || !out_valid_q || out_ready_i);
  assign take       = pop_o && is_decide;
  assign wr_idx     = 2'(head_i.op) - 2'd1;

  // divide the scaled magnitude by 100, clamp, restore sign
  always_comb begin
    s_prod = (MagW + RecipW)'(head_i.surge_mag) * (MagW + RecipW)'(Recip100);
    y_prod = (MagW + RecipW)'(head_i.yaw_mag) * (MagW + RecipW)'(Recip100);
    s_q = s_prod[RecipSh +: DemandW];
    y_q = y_prod[RecipSh +: DemandW];
    s_c = (s_q > DemandMax) ? DemandMax : s_q;
    y_c = (y_q > DemandMax) ? DemandMax : y_q;
    new_surge = head_i.surge_neg ? -$signed(s_c) : $signed(s_c);
    new_yaw   = head_i.yaw_neg ? -$signed(y_c) : $signed(y_c);
  end

  // freshness: age clamps at zero when time runs behind the arrival stamp
  always_comb begin
    for (int i = 0; i < NumSrc; i++) begin
      diff[i]  = {1'b0, head_i.now_ms} - {1'b0, arr_q[i]};
      age[i]   = diff[i][32] ? 32'd0 : diff[i][31:0];
      fresh[i] = seen_q[i] && (timeout_q[i] != 16'd0) && (age[i] <= {16'd0, timeout_q[i]});
    end
  end

  always_comb begin
    sel     = SRC_NONE;
    rsn     = RSN_NONE;
    stop    = 1'b0;
    fclosed = 1'b0;
    d_surge = '0;
    d_yaw   = '0;
    lineage = '0;
    priority if (seen_q[0] && request_q[0]) begin
      lineage = seq_q[0];
      if (valid_q[0] && fresh[0]) begin
        sel     = SRC_HANDSET;
        d_surge = gsurge_q[0];
        d_yaw   = gyaw_q[0];
      end else begin
        stop    = 1'b1;
        fclosed = 1'b1;
        rsn     = valid_q[0] ? RSN_HS_STALE : RSN_HS_INVALID;
      end
    end else if (seen_q[1] && request_q[1]) begin
      lineage = seq_q[1];
      priority if (estop_q[1]) begin
        stop = 1'b1;
        rsn  = RSN_ESTOP;
      end else if (valid_q[1] && fresh[1]) begin
        sel     = SRC_TELEOP;
        d_surge = gsurge_q[1];
        d_yaw   = gyaw_q[1];
      end else begin
        stop    = 1'b1;
        fclosed = 1'b1;
        rsn     = valid_q[1] ? RSN_TEL_STALE : RSN_TEL_INVALID;
      end
    end else begin
      priority if (head_i.halt_all) begin
        stop = 1'b1;
        rsn  = RSN_ALLSTOP;
      end else if (!seen_q[0] && !allow_early_q) begin
        stop = 1'b1;
        rsn  = RSN_STARTUP;
      end else if (valid_q[2] && fresh[2]) begin
        sel     = SRC_AUTONOMY;
        lineage = seq_q[2];
        d_surge = gsurge_q[2];
        d_yaw   = gyaw_q[2];
      end else begin
        stop    = 1'b1;
        lineage = seq_q[2];
        rsn     = valid_q[2] ? RSN_AUT_STALE : RSN_AUT_INVALID;
      end
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q[0]  <= 16'd500;
      timeout_q[1]  <= 16'd500;
      timeout_q[2]  <= 16'd1000;
      allow_early_q <= 1'b1;
      seen_q        <= '0;
      valid_q       <= '0;
      request_q     <= '0;
      estop_q       <= '0;
      for (int i = 0; i < NumSrc; i++) begin
        gsurge_q[i] <= '0;
        gyaw_q[i]   <= '0;
        seq_q[i]    <= '0;
        arr_q[i]    <= '0;
      end
      count_q     <= '0;
      last_src_q  <= SRC_NONE;
      last_rsn_q  <= RSN_STARTUP;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_HS_TIMEOUT:  timeout_q[0]  <= cfg_data_i;
          CFG_TEL_TIMEOUT: timeout_q[1]  <= cfg_data_i;
          CFG_AUT_TIMEOUT: timeout_q[2]  <= cfg_data_i;
          CFG_ALLOW_EARLY: allow_early_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (is_arrival) begin
        for (int i = 0; i < NumSrc; i++) begin
          if (wr_idx == 2'(i)) begin
            seen_q[i]    <= 1'b1;
            valid_q[i]   <= head_i.cmd_valid;
            request_q[i] <= head_i.cmd_request;
            estop_q[i]   <= head_i.cmd_estop;
            gsurge_q[i]  <= new_surge;
            gyaw_q[i]    <= new_yaw;
            seq_q[i]     <= head_i.cmd_seq;
            arr_q[i]     <= head_i.now_ms;
          end
        end
      end
      if (take) begin
        count_q    <= count_q + 32'd1;
        last_src_q <= sel;
        last_rsn_q <= rsn;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_count_q <= count_q + 32'd1;
      o_src_q   <= sel;
      o_stop_q  <= stop;
      o_fc_q    <= fclosed;
      o_rsn_q   <= rsn;
      o_surge_q <= stop ? 11'sd0 : d_surge;
      o_yaw_q   <= stop ? 11'sd0 : d_yaw;
      o_lin_q   <= lineage;
      o_ach_q   <= (sel != last_src_q);
      o_rch_q   <= (rsn != last_rsn_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign decision_count_o    = o_count_q;
  assign grant_src_o         = o_src_q;
  assign thrust_cut_o        = o_stop_q;
  assign manual_fault_o      = o_fc_q;
  assign halt_cause_o        = o_rsn_q;
  assign surge_out_o         = o_surge_q;
  assign yaw_out_o           = o_yaw_q;
  assign lineage_seq_o       = o_lin_q;
  assign owner_changed_o     = o_ach_q;
  assign reason_changed_o    = o_rch_q;

endmodule

[hw/rtl/command_authority_arbiter.sv]
// Command authority arbiter, top level. A decide request taken from the
// queue has its result registered at the output; arrivals give no result.
// Throughput: one request per cycle, set by the two-entry queue draining one
// entry a cycle; a decide waits in the queue only while the output is held.
// Reset (async, active low) empties queue and output, clears the mailboxes
// and loads timeouts 500/500/1000 ms with early autonomy allowed.
module command_authority_arbiter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [31:0]         now_ms_i,
  input  logic                cmd_valid_i,
  input  logic                cmd_request_i,
  input  logic                cmd_estop_i,
  input  logic signed [10:0]  cmd_surge_i,
  input  logic signed [10:0]  cmd_yaw_i,
  input  logic [7:0]          cmd_limit_i,
  input  logic [31:0]         cmd_seq_i,
  input  logic                halt_all_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         decision_count_o,
  output logic [1:0]          grant_src_o,
  output logic                thrust_cut_o,
  output logic                manual_fault_o,
  output logic [3:0]          halt_cause_o,
  output logic signed [10:0]  surge_out_o,
  output logic signed [10:0]  yaw_out_o,
  output logic [31:0]         lineage_seq_o,
  output logic                owner_changed_o,
  output logic                reason_changed_o
);
  import caa_pkg::*;

  entry_t push_entry, head;
  logic   push, full, head_valid, pop;

  caa_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .now_ms_i      (now_ms_i),
    .cmd_valid_i   (cmd_valid_i),
    .cmd_request_i (cmd_request_i),
    .cmd_estop_i   (cmd_estop_i),
    .cmd_surge_i   (cmd_surge_i),
    .cmd_yaw_i     (cmd_yaw_i),
    .cmd_limit_i   (cmd_limit_i),
    .cmd_seq_i     (cmd_seq_i),
    .halt_all_i    (halt_all_i),
    .push_o        (push),
    .entry_o       (push_entry),
    .q_full_i      (full)
  );

  caa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  caa_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .head_valid_i        (head_valid),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .decision_count_o    (decision_count_o),
    .grant_src_o         (grant_src_o),
    .thrust_cut_o        (thrust_cut_o),
    .manual_fault_o      (manual_fault_o),
    .halt_cause_o        (halt_cause_o),
    .surge_out_o         (surge_out_o),
    .yaw_out_o           (yaw_out_o),
    .lineage_seq_o       (lineage_seq_o),
    .owner_changed_o     (owner_changed_o),
    .reason_changed_o    (reason_changed_o)
  );

endmodule

[hw/rtl/caa_checker.sv]
// Port-level checks for the command authority arbiter, bound to the top.
// Depends on caa_pkg for source and reason codes.
module caa_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [31:0]         decision_count_o,
  input  logic [1:0]          grant_src_o,
  input  logic                thrust_cut_o,
  input  logic                manual_fault_o,
  input  logic [3:0]          halt_cause_o,
  input  logic signed [10:0]  surge_out_o,
  input  logic signed [10:0]  yaw_out_o
);
  import caa_pkg::*;

  // held result keeps its decision number
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decision_count_o))
    else $error("result dropped or changed while stalled");

  // a source is granted exactly when there is no stop, and a stop names a reason
  a_grant_vs_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((grant_src_o == SRC_NONE) == thrust_cut_o)
                    && (thrust_cut_o == (halt_cause_o != RSN_NONE)))
    else $error("selected source, stop flag and reason disagree");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && thrust_cut_o |-> surge_out_o == 11'sd0 && yaw_out_o == 11'sd0)
    else $error("thrust granted during a stop");

  a_fail_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && manual_fault_o |->
      halt_cause_o == RSN_HS_INVALID || halt_cause_o == RSN_HS_STALE ||
      halt_cause_o == RSN_TEL_INVALID || halt_cause_o == RSN_TEL_STALE)
    else $error("fail-closed without a manual-source reason");

endmodule

bind command_authority_arbiter caa_checker u_caa_checker (.*);

[sim/tb.sv]
// Testbench for command_authority_arbiter: directed and random requests
// checked against an in-bench arbitration model. Depends on caa_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import caa_pkg::*;

  localparam int HS  = 0;
  localparam int TEL = 1;
  localparam int AUT = 2;
  localparam int IDLE_PCT = 27;
  localparam int SETTLE_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 1_000_000;

  typedef struct {
    op_e                op;
    logic [31:0]        now;
    logic               valid;
    logic               request;
    logic               estop;
    logic signed [10:0] surge;
    logic signed [10:0] yaw;
    logic [7:0]         limit;
    logic [31:0]        seq;
    logic               halt_all;
  } request_t;

  typedef struct {
    logic [31:0]        count;
    src_e               src;
    logic               stop;
    logic               fclosed;
    reason_e            reason;
    logic signed [10:0] surge;
    logic signed [10:0] yaw;
    logic [31:0]        lineage;
    logic               auth_chg;
    logic               rsn_chg;
  } decision_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = '0;
  logic [31:0]        now_ms = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_request = 1'b0;
  logic               cmd_estop = 1'b0;
  logic signed [10:0] cmd_surge = '0;
  logic signed [10:0] cmd_yaw = '0;
  logic [7:0]         cmd_limit = '0;
  logic [31:0]        cmd_seq = '0;
  logic               halt_all = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        decision_count;
  logic [1:0]         grant_src;
  logic               thrust_cut;
  logic               manual_fault;
  logic [3:0]         halt_cause;
  logic signed [10:0] surge_out;
  logic signed [10:0] yaw_out;
  logic [31:0]        lineage_seq;
  logic               owner_changed;
  logic               reason_changed;

  command_authority_arbiter DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .operation_i         (operation),
    .now_ms_i            (now_ms),
    .cmd_valid_i         (cmd_valid),
    .cmd_request_i       (cmd_request),
    .cmd_estop_i         (cmd_estop),
    .cmd_surge_i         (cmd_surge),
    .cmd_yaw_i           (cmd_yaw),
    .cmd_limit_i         (cmd_limit),
    .cmd_seq_i           (cmd_seq),
    .halt_all_i          (halt_all),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .decision_count_o    (decision_count),
    .grant_src_o         (grant_src),
    .thrust_cut_o        (thrust_cut),
    .manual_fault_o      (manual_fault),
    .halt_cause_o        (halt_cause),
    .surge_out_o         (surge_out),
    .yaw_out_o           (yaw_out),
    .lineage_seq_o       (lineage_seq),
    .owner_changed_o     (owner_changed),
    .reason_changed_o    (reason_changed)
  );

  // Arbitration model state
  logic [15:0]        timeout_ms [NumSrc];
  logic               allow_early;
  logic               seen_q     [NumSrc];
  logic               valid_q    [NumSrc];
  logic               request_q  [NumSrc];
  logic               estop_q    [NumSrc];
  logic signed [10:0] surge_q    [NumSrc];
  logic signed [10:0] yaw_q      [NumSrc];
  logic [7:0]         limit_q    [NumSrc];
  logic [31:0]        seq_q      [NumSrc];
  logic [31:0]        arrival_q  [NumSrc];
  logic [31:0]        decisions_made;
  src_e               prev_src;
  reason_e            prev_reason;

  decision_t          decisions_due[$];
  int                 fail_count = 0;
  bit                 steady = 1'b0;
  logic [31:0]        sim_ms;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_model();
    timeout_ms[HS]  = 16'd500;
    timeout_ms[TEL] = 16'd500;
    timeout_ms[AUT] = 16'd1000;
    allow_early = 1'b1;
    for (int s = 0; s < NumSrc; s++) begin
      seen_q[s] = 0; valid_q[s] = 0; request_q[s] = 0; estop_q[s] = 0;
      surge_q[s] = 0; yaw_q[s] = 0; limit_q[s] = 0; seq_q[s] = 0; arrival_q[s] = 0;
    end
    decisions_made = 0;
    prev_src = SRC_NONE;
    prev_reason = RSN_STARTUP;
  endfunction

  function automatic bit is_current(int s, logic [31:0] now);
    logic [31:0] age;
    if (!seen_q[s] || timeout_ms[s] == 16'd0) return 1'b0;
    age = (now >= arrival_q[s]) ? now - arrival_q[s] : 32'd0;
    return age <= {16'd0, timeout_ms[s]};
  endfunction

  function automatic int scaled(logic signed [10:0] v, logic [7:0] lim);
    int k;
    k = (lim > 8'd100) ? 100 : int'(lim);
    return (int'(v) * k) / 100;
  endfunction

  function automatic logic signed [10:0] clamp_demand(int v);
    if (v > 1000) return 11'sd1000;
    if (v < -1000) return -11'sd1000;
    return 11'(v);
  endfunction

  function automatic decision_t arbitrate(request_t r);
    decision_t d;
    int        s_out;
    int        y_out;
    logic      v;
    d.src = SRC_NONE; d.reason = RSN_NONE; d.stop = 0; d.fclosed = 0; d.lineage = 0;
    s_out = 0; y_out = 0;
    decisions_made = decisions_made + 32'd1;
    d.count = decisions_made;
    if (seen_q[HS] && request_q[HS]) begin
      v = valid_q[HS];
      d.lineage = seq_q[HS];
      if (v && is_current(HS, r.now)) begin
        d.src = SRC_HANDSET;
        s_out = scaled(surge_q[HS], limit_q[HS]);
        y_out = scaled(yaw_q[HS], limit_q[HS]);
      end else begin
        d.stop = 1; d.fclosed = 1;
        d.reason = v ? RSN_HS_STALE : RSN_HS_INVALID;
      end
    end else if (seen_q[TEL] && request_q[TEL]) begin
      v = valid_q[TEL];
      d.lineage = seq_q[TEL];
      if (estop_q[TEL]) begin
        d.stop = 1; d.reason = RSN_ESTOP;
      end else if (v && is_current(TEL, r.now)) begin
        d.src = SRC_TELEOP;
        s_out = scaled(surge_q[TEL], limit_q[TEL]);
        y_out = scaled(yaw_q[TEL], limit_q[TEL]);
      end else begin
        d.stop = 1; d.fclosed = 1;
        d.reason = v ? RSN_TEL_STALE : RSN_TEL_INVALID;
      end
    end else begin
      v = valid_q[AUT];
      if (r.halt_all) begin
        d.stop = 1; d.reason = RSN_ALLSTOP;
      end else if (!seen_q[HS] && !allow_early) begin
        d.stop = 1; d.reason = RSN_STARTUP;
      end else if (v && is_current(AUT, r.now)) begin
        d.src = SRC_AUTONOMY;
        d.lineage = seq_q[AUT];
        s_out = int'(surge_q[AUT]);
        y_out = int'(yaw_q[AUT]);
      end else begin
        d.stop = 1;
        d.lineage = seq_q[AUT];
        d.reason = v ? RSN_AUT_STALE : RSN_AUT_INVALID;
      end
    end
    if (d.stop) begin
      s_out = 0; y_out = 0;
    end
    d.surge = clamp_demand(s_out);
    d.yaw = clamp_demand(y_out);
    d.auth_chg = (d.src != prev_src);
    d.rsn_chg = (d.reason != prev_reason);
    prev_src = d.src;
    prev_reason = d.reason;
    return d;
  endfunction

  function automatic void apply_request(request_t r);
    int s;
    if (r.op == OP_DECIDE) begin
      decisions_due.push_back(arbitrate(r));
    end else begin
      s = int'(r.op) - 1;
      seen_q[s] = 1'b1;
      valid_q[s] = r.valid;
      request_q[s] = (s == AUT) ? 1'b0 : r.request;
      estop_q[s] = (s == TEL) ? r.estop : 1'b0;
      surge_q[s] = r.surge;
      yaw_q[s] = r.yaw;
      limit_q[s] = r.limit;
      seq_q[s] = r.seq;
      arrival_q[s] = r.now;
    end
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(request_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    operation   <= r.op;
    now_ms      <= r.now;
    cmd_valid   <= r.valid;
    cmd_request <= r.request;
    cmd_estop   <= r.estop;
    cmd_surge   <= r.surge;
    cmd_yaw     <= r.yaw;
    cmd_limit   <= r.limit;
    cmd_seq     <= r.seq;
    halt_all    <= r.halt_all;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    apply_request(r);
    @(negedge clk_i);
  endtask

  task automatic arrive(op_e op, logic [31:0] now, bit valid, bit req, bit estop,
                        int surge, int yaw, int limit, logic [31:0] seq);
    request_t r;
    r.op = op; r.now = now; r.valid = valid; r.request = req; r.estop = estop;
    r.surge = 11'(surge); r.yaw = 11'(yaw); r.limit = 8'(limit); r.seq = seq;
    r.halt_all = 1'b0;
    send_request(r);
  endtask

  task automatic tick(logic [31:0] now, bit stop_all);
    request_t r;
    r.op = OP_DECIDE; r.now = now; r.valid = 0; r.request = 0; r.estop = 0;
    r.surge = 0; r.yaw = 0; r.limit = 0; r.seq = 0; r.halt_all = stop_all;
    send_request(r);
  endtask

  // Lets queued arrivals retire too, since they give no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [15:0] hs_to, logic [15:0] tel_to,
                                logic [15:0] aut_to, logic allow);
    wait_drained();
    cfg_we <= 1'b1; cfg_idx <= CFG_HS_TIMEOUT; cfg_data <= hs_to;
    @(negedge clk_i);
    cfg_idx <= CFG_TEL_TIMEOUT; cfg_data <= tel_to;
    @(negedge clk_i);
    cfg_idx <= CFG_AUT_TIMEOUT; cfg_data <= aut_to;
    @(negedge clk_i);
    cfg_idx <= CFG_ALLOW_EARLY; cfg_data <= {15'd0, allow};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    timeout_ms[HS] = hs_to;
    timeout_ms[TEL] = tel_to;
    timeout_ms[AUT] = aut_to;
    allow_early = allow;
  endtask

  function automatic request_t random_request(int unsigned step_max);
    request_t    r;
    int unsigned pick;
    sim_ms = sim_ms + $urandom_range(step_max);
    pick = $urandom_range(99);
    if (pick < 5) r.now = $urandom();
    else if (pick < 10) r.now = sim_ms - $urandom_range(step_max);
    else r.now = sim_ms;
    pick = $urandom_range(9);
    if (pick < 4) r.op = OP_DECIDE;
    else if (pick < 6) r.op = OP_HANDSET;
    else if (pick < 8) r.op = OP_TELEOP;
    else r.op = OP_AUTONOMY;
    r.valid = ($urandom_range(99) < 85);
    case (r.op)
      OP_HANDSET: r.request = ($urandom_range(99) < 30);
      OP_TELEOP:  r.request = ($urandom_range(99) < 50);
      default:    r.request = 1'($urandom_range(1));
    endcase
    r.estop = (r.op == OP_TELEOP) ? ($urandom_range(99) < 15) : 1'($urandom_range(1));
    r.surge = ($urandom_range(99) < 70) ? 11'($urandom_range(2000) - 1000) : 11'($urandom());
    r.yaw   = ($urandom_range(99) < 70) ? 11'($urandom_range(2000) - 1000) : 11'($urandom());
    r.limit = ($urandom_range(99) < 70) ? 8'($urandom_range(110)) : 8'($urandom());
    r.seq = $urandom();
    r.halt_all = ($urandom_range(99) < 15);
    return r;
  endfunction

  task automatic run_phase(logic [15:0] hs_to, logic [15:0] tel_to, logic [15:0] aut_to,
                           logic allow, int n);
    int unsigned top;
    apply_settings(hs_to, tel_to, aut_to, allow);
    top = hs_to;
    if (tel_to > top) top = tel_to;
    if (aut_to > top) top = aut_to;
    top = (top == 0) ? 100 : top / 3 + 2;
    // some phases run across the 32-bit wrap of the millisecond clock
    sim_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom();
    repeat (n) send_request(random_request(top));
  endtask

  task automatic test_startup_gating();
    tick(32'd100, 1'b0);                      // autonomy never seen: invalid
    apply_settings(16'd500, 16'd500, 16'd1000, 1'b0);
    tick(32'd100, 1'b0);                      // no handset yet: startup hold
    tick(32'd100, 1'b1);
  endtask

  task automatic test_autonomy_path();
    apply_settings(16'd500, 16'd500, 16'd1000, 1'b1);
    arrive(OP_AUTONOMY, 32'd1000, 1, 1, 1, 1023, -1024, 255, 32'hFFFF_FFFF);
    tick(32'd1000, 1'b0);                     // unscaled, saturated
    tick(32'd500, 1'b0);                      // clock behind arrival counts as age 0
    tick(32'd2001, 1'b0);
    tick(32'd2000, 1'b0);                     // age equal to timeout is fresh
    arrive(OP_AUTONOMY, 32'd2000, 0, 0, 0, 10, 10, 50, 32'd7);
    tick(32'd2000, 1'b0);
  endtask

  task automatic test_handset_path();
    arrive(OP_HANDSET, 32'd3000, 1, 1, 1, -1024, 1023, 100, 32'd0);
    tick(32'd3500, 1'b0);
    arrive(OP_HANDSET, 32'd3500, 1, 1, 0, 999, -999, 0, 32'h8000_0001);
    tick(32'd3999, 1'b0);
    tick(32'd4001, 1'b0);
    arrive(OP_HANDSET, 32'd4001, 0, 1, 0, 300, 300, 80, 32'd42);
    tick(32'd4001, 1'b0);
  endtask

  task automatic test_teleop_path();
    arrive(OP_HANDSET, 32'd5000, 1, 0, 0, 0, 0, 100, 32'd43);
    arrive(OP_TELEOP, 32'd5000, 1, 1, 0, 500, -501, 99, 32'h1234_5678);
    tick(32'd5000, 1'b1);                     // all-stop does not gate teleop
    tick(32'd5501, 1'b0);
    arrive(OP_TELEOP, 32'd5501, 0, 1, 1, 100, 100, 100, 32'd99);
    tick(32'd5501, 1'b0);                     // estop beats invalid
    apply_settings(16'd500, 16'd0, 16'd1000, 1'b1);
    arrive(OP_TELEOP, 32'd6000, 1, 1, 0, 200, 200, 100, 32'd100);
    tick(32'd6000, 1'b0);                     // zero timeout: never fresh
  endtask

  task automatic test_random_traffic();
    run_phase(16'd500, 16'd500, 16'd1000, 1'b1, 220);
    run_phase(16'd1, 16'd1, 16'd1, 1'b0, 200);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 200);
    run_phase(16'd0, 16'd0, 16'd0, 1'b0, 150);
    run_phase(16'd0, 16'd40, 16'd300, 1'b1, 200);
    repeat (2) begin
      run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                16'($urandom_range(1, 2000)), 1'($urandom_range(1)), 200);
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_phase(16'd200, 16'd300, 16'd400, 1'b1, 80);
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_startup_gating();
    test_autonomy_path();
    test_handset_path();
    test_teleop_path();
    test_random_traffic();
    test_back_to_back();
    wait_drained();
    if (fail_count == 0 && decisions_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    decision_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (decisions_due.size() == 0) begin
        $error("decision with no decide request pending");
        fail_count++;
      end else begin
        want = decisions_due.pop_front();
        check_field("decision_count", longint'(want.count), longint'(decision_count));
        check_field("grant_src", longint'(want.src), longint'(grant_src));
        check_field("thrust_cut", longint'(want.stop), longint'(thrust_cut));
        check_field("manual_fault", longint'(want.fclosed), longint'(manual_fault));
        check_field("halt_cause", longint'(want.reason), longint'(halt_cause));
        check_field("surge_out", longint'(want.surge), longint'(surge_out));
        check_field("yaw_out", longint'(want.yaw), longint'(yaw_out));
        check_field("lineage_seq", longint'(want.lineage), longint'(lineage_seq));
        check_field("owner_changed", longint'(want.auth_chg),
                    longint'(owner_changed));
        check_field("reason_changed", longint'(want.rsn_chg), longint'(reason_changed));
      end
    end
  end

endmodule

[command_authority_arbiter.f]
hw/rtl/caa_pkg.sv
hw/rtl/caa_front.sv
hw/rtl/caa_queue.sv
hw/rtl/caa_back.sv
hw/rtl/command_authority_arbiter.sv
hw/rtl/caa_checker.sv
sim/tb.sv
